@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the keypad debounce RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define KDL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kdl assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KDL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kdl assertion failed");

`else

`define KDL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KDL_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/kdl_pkg.sv @@
// Package for the keypad debounce / long-press unit: widths, codes, types,
// key map and matrix resolve function. No dependencies.
`default_nettype none

package kdl_pkg;

    localparam int SENSE_W     = 9;
    localparam int KEY_W       = 4;
    localparam int VALUE_W     = 5;
    localparam int TIME_W      = 8;
    localparam int HOLD_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int MATRIX_DIM  = 3;
    localparam int KEY_COUNT   = 9;
    localparam int NUM_KEYS_DEF = 9;

    // Input command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ON_TIME    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REJECT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TIME   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd3;

    // Reset values of the configuration registers
    localparam logic [TIME_W-1:0] ON_TIME_RST    = 8'd3;
    localparam logic [TIME_W-1:0] REJECT_RST     = 8'd36;
    localparam logic [TIME_W-1:0] OFF_TIME_RST   = 8'd5;
    localparam logic [HOLD_W-1:0] LONG_PRESS_RST = 16'd100;

    // Long-press fast code = key code + FAST_OFFSET
    localparam logic [VALUE_W-1:0] FAST_OFFSET = 5'd9;

    typedef struct packed {
        logic [TIME_W-1:0] on_time;
        logic [TIME_W-1:0] reject_time;
        logic [TIME_W-1:0] off_time;
        logic [HOLD_W-1:0] long_press_ticks;
    } cfg_t;

    typedef struct packed {
        logic               cmd;
        logic [SENSE_W-1:0] sense;
    } item_t;

    // Key code at matrix position row*3+col
    function automatic logic [KEY_W-1:0] key_map(input int unsigned pos);
        logic [KEY_W-1:0] code;
        unique case (pos)
            0:       code = 4'd1;
            1:       code = 4'd9;
            2:       code = 4'd8;
            3:       code = 4'd5;
            4:       code = 4'd2;
            5:       code = 4'd7;
            6:       code = 4'd3;
            7:       code = 4'd4;
            8:       code = 4'd6;
            default: code = 4'd0;
        endcase
        return code;
    endfunction

    // Highest row with a hit wins; lowest column within that row.
    function automatic logic [KEY_W-1:0] resolve(input logic [SENSE_W-1:0] sense);
        logic [KEY_W-1:0] code;
        logic             found;
        code = '0;
        for (int r = 0; r < MATRIX_DIM; r++) begin
            found = 1'b0;
            for (int c = 0; c < MATRIX_DIM; c++) begin
                if (!found && sense[r*MATRIX_DIM + c]) begin
                    code  = key_map(r*MATRIX_DIM + c);
                    found = 1'b1;
                end
            end
        end
        return code;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/kdl_if.sv @@
// Handshake channel interfaces for the keypad debounce unit.
// Depends on kdl_pkg for field widths.
`default_nettype none

interface kdl_req_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [kdl_pkg::SENSE_W-1:0]  sense;

    modport source (output valid, output cmd, output sense, input ready);
    modport sink   (input valid, input cmd, input sense, output ready);
endinterface

interface kdl_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [kdl_pkg::VALUE_W-1:0]  key_value;

    modport source (output valid, output key_value, input ready);
    modport sink   (input valid, input key_value, output ready);
endinterface

interface kdl_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [kdl_pkg::CFG_IDX_W-1:0]   index;
    logic [kdl_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/kdl_cfg_regs.sv @@
// Configuration register file of the keypad debounce unit.
// Depends on kdl_pkg.
`default_nettype none

module kdl_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            wr_en,
    input  wire logic [kdl_pkg::CFG_IDX_W-1:0]   wr_index,
    input  wire logic [kdl_pkg::CFG_DATA_W-1:0]  wr_data,
    output kdl_pkg::cfg_t                        cfg
);

    kdl_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            cfg_reg.on_time          <= kdl_pkg::ON_TIME_RST;
            cfg_reg.reject_time      <= kdl_pkg::REJECT_RST;
            cfg_reg.off_time         <= kdl_pkg::OFF_TIME_RST;
            cfg_reg.long_press_ticks <= kdl_pkg::LONG_PRESS_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                kdl_pkg::REG_ON_TIME:
                    cfg_reg.on_time <= wr_data[kdl_pkg::TIME_W-1:0];
                kdl_pkg::REG_REJECT:
                    cfg_reg.reject_time <= wr_data[kdl_pkg::TIME_W-1:0];
                kdl_pkg::REG_OFF_TIME:
                    cfg_reg.off_time <= wr_data[kdl_pkg::TIME_W-1:0];
                kdl_pkg::REG_LONG_PRESS:
                    cfg_reg.long_press_ticks <= wr_data[kdl_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ hw/rtl/kdl_engine.sv @@
// Debounce sequencer, per-key hold counters, key latch and read logic.
// Depends on kdl_pkg (types, resolve function).
`default_nettype none

module kdl_engine #(
    parameter int NUM_KEYS = kdl_pkg::NUM_KEYS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire kdl_pkg::item_t                item,
    input  wire kdl_pkg::cfg_t                 cfg,
    output logic [kdl_pkg::VALUE_W-1:0]        read_value
);

    localparam int NumRead = (NUM_KEYS < kdl_pkg::KEY_COUNT) ? NUM_KEYS : kdl_pkg::KEY_COUNT;
    localparam int SelW    = $clog2(kdl_pkg::KEY_COUNT);
    localparam logic [kdl_pkg::HOLD_W-1:0] HoldMax = '1;

    typedef enum logic [2:0] {
        ST_NOP, ST_SOME, ST_ON_TIME, ST_CATCH, ST_REJECT, ST_OFF, ST_OFF_TIME, ST_END
    } seq_state_t;

    seq_state_t                      state_reg, state_next;
    logic [kdl_pkg::TIME_W-1:0]      countdown_reg, countdown_next;
    logic [kdl_pkg::KEY_W-1:0]       candidate_reg, candidate_next;
    logic [kdl_pkg::KEY_W-1:0]       latched_reg, latched_next;
    logic [kdl_pkg::HOLD_W-1:0]      hold_reg  [NUM_KEYS];
    logic [kdl_pkg::HOLD_W-1:0]      hold_next [NUM_KEYS];

    logic [kdl_pkg::KEY_W-1:0]       key;
    logic [kdl_pkg::TIME_W-1:0]      cd_dec;
    logic                            sel_found;
    logic [SelW-1:0]                 sel_idx;

    always_comb begin
        key = kdl_pkg::resolve(item.sense);
        cd_dec = (countdown_reg != '0) ? countdown_reg - 1'b1 : countdown_reg;

        // First long-held key in ascending code order
        sel_found = 1'b0;
        sel_idx   = '0;
        for (int i = 0; i < NumRead; i++) begin
            if (!sel_found && hold_reg[i] >= cfg.long_press_ticks) begin
                sel_found = 1'b1;
                sel_idx   = SelW'(i);
            end
        end
        read_value = sel_found ? kdl_pkg::VALUE_W'(sel_idx) + kdl_pkg::FAST_OFFSET + 1'b1
                               : {1'b0, latched_reg};

        state_next     = state_reg;
        countdown_next = countdown_reg;
        candidate_next = candidate_reg;
        latched_next   = latched_reg;
        for (int i = 0; i < NUM_KEYS; i++) begin
            hold_next[i] = hold_reg[i];
        end

        if (step && item.cmd == kdl_pkg::CMD_TICK)
        begin
            countdown_next = cd_dec;
            for (int i = 0; i < NUM_KEYS; i++) begin
                if (key == '0)
                    hold_next[i] = '0;
                else if ({1'b0, key} == 5'(i + 1) && hold_reg[i] != HoldMax)
                    hold_next[i] = hold_reg[i] + 1'b1;
            end
            unique case (state_reg)
                ST_NOP:
                begin
                    if (key != '0)
                    begin
                        candidate_next = key;
                        state_next     = ST_SOME;
                    end
                end
                ST_SOME:
                begin
                    if (key != '0 && key == candidate_reg)
                    begin
                        countdown_next = cfg.on_time;
                        state_next     = ST_ON_TIME;
                    end
                    else
                        state_next = ST_NOP;
                end
                ST_ON_TIME:
                begin
                    if (key != candidate_reg)
                        state_next = ST_NOP;
                    else if (cd_dec == '0)
                        state_next = ST_CATCH;
                end
                ST_CATCH:
                begin
                    latched_next   = candidate_reg;
                    countdown_next = cfg.reject_time;
                    state_next     = ST_REJECT;
                end
                ST_REJECT:
                begin
                    if (cd_dec == '0)
                        state_next = ST_OFF;
                end
                ST_OFF:
                begin
                    if (key == '0)
                    begin
                        countdown_next = cfg.off_time;
                        state_next     = ST_OFF_TIME;
                    end
                end
                ST_OFF_TIME:
                begin
                    if (key != '0)
                        state_next = ST_OFF;
                    else if (cd_dec == '0)
                        state_next = ST_END;
                end
                ST_END:
                    state_next = ST_NOP;
            endcase
        end
        else if (step)
        begin
            // Read: clamp the reported counter, drop the latch
            latched_next = '0;
            for (int i = 0; i < NumRead; i++) begin
                if (sel_found && sel_idx == SelW'(i))
                    hold_next[i] = cfg.long_press_ticks;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= ST_NOP;
            countdown_reg <= '0;
            candidate_reg <= '0;
            latched_reg   <= '0;
            for (int i = 0; i < NUM_KEYS; i++) begin
                hold_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            countdown_reg <= countdown_next;
            candidate_reg <= candidate_next;
            latched_reg   <= latched_next;
            for (int i = 0; i < NUM_KEYS; i++) begin
                hold_reg[i] <= hold_next[i];
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/keypad_debounce_longpress_unit.sv @@
// Top level of the keypad debounce / long-press unit: input stage, result
// register, config registers and engine. Depends on kdl_pkg, kdl_if.sv,
// kdl_cfg_regs, kdl_engine and assert_macros.svh.
//
//  channel | role  | transfer carries
//  --------+-------+-----------------------------------------
//  req     | sink  | cmd (tick / read), sense[8:0] matrix hits
//  rsp     | src   | key_value[4:0], one per read
//  cfg     | sink  | index[1:0], data[15:0]; always ready
//
// Throughput: one item per cycle unless a stalled rsp holds a read. A read
// passes through the stage register, then the result register, before it is
// presented on rsp; a tick updates state in the stage cycle and yields nothing.
// All item work is a single pass through the engine between the stage
// register and the result register.
// Reset (rst_n low, async) returns the sequencer to nop, clears counters,
// latch and both pipeline valids, and loads the config defaults.
// A stalled rsp keeps a read in the result register; ticks behind it keep
// flowing, and the next read waits in the stage with req.ready low.
`default_nettype none

`include "assert_macros.svh"

module keypad_debounce_longpress_unit #(
    parameter int NUM_KEYS = kdl_pkg::NUM_KEYS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    kdl_req_if.sink    req,
    kdl_rsp_if.source  rsp,
    kdl_cfg_if.sink    cfg
);

    // Input stage
    logic                         stage_valid_reg;
    kdl_pkg::item_t               stage_item_reg;
    logic                         stage_advance;
    logic                         req_transfer;

    // Result register
    logic                         out_valid_reg;
    logic [kdl_pkg::VALUE_W-1:0]  out_value_reg;

    kdl_pkg::cfg_t                cfg_q;
    logic [kdl_pkg::VALUE_W-1:0]  read_value;
    logic                         read_fire;

    // Stage moves on when it holds a tick, or when the result slot frees up
    assign stage_advance = stage_valid_reg &&
                           (stage_item_reg.cmd == kdl_pkg::CMD_TICK ||
                            !out_valid_reg || rsp.ready);
    assign read_fire     = stage_advance && stage_item_reg.cmd == kdl_pkg::CMD_READ;
    assign req.ready     = !stage_valid_reg || stage_advance;
    assign req_transfer  = req.valid && req.ready;

    assign cfg.ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (req.ready)
            stage_valid_reg <= req.valid;
    end

    always_ff @(posedge clk) begin
        if (req_transfer)
        begin
            stage_item_reg.cmd   <= req.cmd;
            stage_item_reg.sense <= req.sense;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (read_fire)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk) begin
        if (read_fire)
            out_value_reg <= read_value;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.key_value = out_value_reg;

    kdl_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_q)
    );

    kdl_engine #(
        .NUM_KEYS (NUM_KEYS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (stage_advance),
        .item       (stage_item_reg),
        .cfg        (cfg_q),
        .read_value (read_value)
    );

    // A read leaving the stage is always presented on rsp next cycle
    `KDL_ASSERT_NXT(a_read_to_rsp, clk, rst_n, read_fire, out_valid_reg)
    // A held stage item is never dropped
    `KDL_ASSERT_NXT(a_stage_kept, clk, rst_n, stage_valid_reg && !stage_advance, stage_valid_reg)
    // A new result only appears after a read left the stage
    `KDL_ASSERT_IMP(a_rsp_source, clk, rst_n, $rose(out_valid_reg), $past(read_fire))
    // Reported values stay within the key and fast code range
    `KDL_ASSERT_IMP(a_value_range, clk, rst_n, out_valid_reg, out_value_reg <= 5'd18)

endmodule

`default_nettype wire
